### rtl/core/lile_pkg.sv
package lile_pkg;

  // Field widths fixed by the interface.
  localparam int IDX_W = 10;
  localparam int MODE_W = 3;

  // Default pool size, entry 0 being the root sentinel.
  localparam int NODE_COUNT_DEF = 1024;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_ADD_HEAD  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_TAIL  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MOVE_HEAD = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MOVE_TAIL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd4;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_CLEAR,
    DP_LOAD,
    DP_EVAL,
    DP_UNLINK_A,
    DP_UNLINK_B,
    DP_HEAD_A,
    DP_HEAD_B,
    DP_TAIL_A,
    DP_TAIL_B,
    DP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic guard_ok;
    logic do_unlink;
    logic link_head;
    logic link_tail;
    logic out_busy;
  } dp_status_t;

endpackage

### rtl/core/lru_index_list_engine_core.sv
// LRU index list engine: a circular doubly linked list over a pool of
// NODE_COUNT nodes, entry 0 being the root sentinel.
// Input channel (in_valid/in_ready) carries one request: mode and
// node_index. Output channel (out_valid/out_ready) returns one result per
// request: applied, list_empty, head_index and tail_index.
// Configuration channel (cfg_valid/cfg_ready, cfg_data) writes lru_enable;
// it is always ready and should be used only while the block is idle.
// Requests are handled one at a time: accept, link read, then two write
// steps per link change, then a done step that loads the result register
// once the output register is free; in_ready rises at that same edge. The
// prev and next link memories have one write port each, which sets the
// two write steps per unlink and per insertion.
// After reset a clearing pass over all NODE_COUNT entries points every link
// at its own entry; in_ready stays low during it.
// A result waits in the output register while the receiver stalls; the
// next request may be accepted meanwhile, but its result is held back
// until the waiting one is taken.
module lru_index_list_engine_core #(
  parameter int NODE_COUNT = lile_pkg::NODE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lile_pkg::MODE_W-1:0] mode,
  input  logic [lile_pkg::IDX_W-1:0]  node_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        applied,
  output logic                        list_empty,
  output logic [lile_pkg::IDX_W-1:0]  head_index,
  output logic [lile_pkg::IDX_W-1:0]  tail_index
);

  lile_pkg::dp_cmd_t    cmd;
  lile_pkg::dp_status_t status;

  // Configuration writes are always accepted.
  assign cfg_ready = 1'b1;

  lile_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lile_datapath #(.NODE_COUNT(NODE_COUNT)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .mode       (mode),
    .node_index (node_index),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .applied    (applied),
    .list_empty (list_empty),
    .head_index (head_index),
    .tail_index (tail_index)
  );

  // A waiting result is never overwritten by the next one.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> (cmd.op != lile_pkg::DP_RESULT))
    else $error("result issued while previous result stalled");

  // Loading a result always raises out_valid.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == lile_pkg::DP_RESULT) |=> out_valid)
    else $error("result loaded without out_valid");

  // Only one request in flight.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted while busy");

  // A reported empty list has both root links at the root.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (list_empty == (head_index == '0)) &&
                  (!list_empty || (tail_index == '0)))
    else $error("empty flag disagrees with head and tail");

endmodule

### rtl/core/lile_ram.sv
module lile_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/lile_datapath.sv
module lile_datapath #(
  parameter int NODE_COUNT = lile_pkg::NODE_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lile_pkg::dp_cmd_t            cmd,
  output lile_pkg::dp_status_t         status,
  input  logic                         cfg_we,
  input  logic                         cfg_data,
  input  logic [lile_pkg::MODE_W-1:0]  mode,
  input  logic [lile_pkg::IDX_W-1:0]   node_index,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         applied,
  output logic                         list_empty,
  output logic [lile_pkg::IDX_W-1:0]   head_index,
  output logic [lile_pkg::IDX_W-1:0]   tail_index
);

  localparam int AW = $clog2(NODE_COUNT);

  typedef logic [AW-1:0] addr_t;

  // Latched request and working values.
  logic [lile_pkg::MODE_W-1:0] op_mode;
  addr_t node;
  logic  node_ok;
  addr_t link_p;
  addr_t link_q;
  addr_t tail_cap;
  logic  ok;
  logic  lru_enable;
  addr_t clr_cnt;

  // Root links live in flops: head is next of root, tail is prev of root.
  addr_t head;
  addr_t tail;

  logic [31:0] idx_ext;
  logic [31:0] head_ext;
  logic [31:0] tail_ext;
  logic        in_range;
  addr_t       rd_addr;
  addr_t       prev_rd;
  addr_t       next_rd;

  logic  pw_en;
  addr_t pw_addr;
  addr_t pw_data;
  logic  nw_en;
  addr_t nw_addr;
  addr_t nw_data;

  logic unlinked;
  logic guard;

  assign idx_ext  = 32'(node_index);
  assign in_range = idx_ext < 32'(NODE_COUNT);
  assign rd_addr  = (cmd.op == lile_pkg::DP_LOAD) ? idx_ext[AW-1:0] : node;

  // Link tables for all pool entries; the root entry in them is never used.
  lile_ram #(.WIDTH(AW), .DEPTH(NODE_COUNT)) u_prev_ram (
    .clk   (clk),
    .we    (pw_en),
    .waddr (pw_addr),
    .wdata (pw_data),
    .raddr (rd_addr),
    .rdata (prev_rd)
  );

  lile_ram #(.WIDTH(AW), .DEPTH(NODE_COUNT)) u_next_ram (
    .clk   (clk),
    .we    (nw_en),
    .waddr (nw_addr),
    .wdata (nw_data),
    .raddr (rd_addr),
    .rdata (next_rd)
  );

  // Guard check on the node's links as read back in the evaluate step.
  always_comb begin
    unlinked = (prev_rd == node) && (next_rd == node);
    guard    = 1'b0;
    case (op_mode)
      lile_pkg::MODE_ADD_HEAD: begin
        guard = (prev_rd != '0) && unlinked;
      end
      lile_pkg::MODE_ADD_TAIL: begin
        guard = lru_enable && (next_rd != '0) && unlinked;
      end
      lile_pkg::MODE_MOVE_HEAD: begin
        guard = lru_enable && (prev_rd != '0) && (next_rd != node) &&
                (prev_rd != node) && (next_rd != prev_rd);
      end
      lile_pkg::MODE_MOVE_TAIL: begin
        guard = lru_enable && (next_rd != '0) && (next_rd != node) &&
                (prev_rd != node) && (next_rd != prev_rd);
      end
      lile_pkg::MODE_REMOVE: begin
        guard = (next_rd != node) && (prev_rd != node);
      end
      default: begin
        guard = 1'b0;
      end
    endcase
    guard = guard && node_ok && (node != '0);
  end

  // Which steps the latched operation needs.
  always_comb begin
    status.do_unlink = 1'b0;
    status.link_head = 1'b0;
    status.link_tail = 1'b0;
    case (op_mode) inside
      lile_pkg::MODE_ADD_HEAD: begin
        status.link_head = 1'b1;
      end
      lile_pkg::MODE_ADD_TAIL: begin
        status.link_tail = 1'b1;
      end
      lile_pkg::MODE_MOVE_HEAD: begin
        status.do_unlink = 1'b1;
        status.link_head = 1'b1;
      end
      lile_pkg::MODE_MOVE_TAIL: begin
        status.do_unlink = 1'b1;
        status.link_tail = 1'b1;
      end
      lile_pkg::MODE_REMOVE: begin
        status.do_unlink = 1'b1;
      end
      default: begin
        status.do_unlink = 1'b0;
      end
    endcase
    status.guard_ok   = guard;
    status.clear_last = clr_cnt == AW'(NODE_COUNT - 1);
    status.out_busy   = out_valid && !out_ready;
  end

  // Write port selection. Each step writes at most one prev and one next
  // entry, kept in the same per-table order as the sequential update.
  always_comb begin
    pw_en   = 1'b0;
    pw_addr = node;
    pw_data = node;
    nw_en   = 1'b0;
    nw_addr = node;
    nw_data = node;
    case (cmd.op)
      lile_pkg::DP_CLEAR: begin
        pw_en   = 1'b1;
        pw_addr = clr_cnt;
        pw_data = clr_cnt;
        nw_en   = 1'b1;
        nw_addr = clr_cnt;
        nw_data = clr_cnt;
      end
      lile_pkg::DP_UNLINK_A: begin
        pw_en   = 1'b1;
        pw_addr = link_q;
        pw_data = link_p;
        nw_en   = 1'b1;
        nw_addr = link_p;
        nw_data = link_q;
      end
      lile_pkg::DP_UNLINK_B: begin
        pw_en = 1'b1;
        nw_en = 1'b1;
      end
      lile_pkg::DP_HEAD_A: begin
        pw_en   = 1'b1;
        pw_addr = head;
        pw_data = node;
        nw_en   = 1'b1;
        nw_addr = node;
        nw_data = head;
      end
      lile_pkg::DP_HEAD_B: begin
        pw_en   = 1'b1;
        pw_addr = node;
        pw_data = '0;
        nw_en   = 1'b1;
        nw_addr = '0;
        nw_data = node;
      end
      lile_pkg::DP_TAIL_A: begin
        pw_en   = 1'b1;
        pw_addr = '0;
        pw_data = node;
        nw_en   = 1'b1;
        nw_addr = node;
        nw_data = '0;
      end
      lile_pkg::DP_TAIL_B: begin
        pw_en   = 1'b1;
        pw_addr = node;
        pw_data = tail_cap;
        nw_en   = 1'b1;
        nw_addr = tail_cap;
        nw_data = node;
      end
      default: begin
        pw_en = 1'b0;
        nw_en = 1'b0;
      end
    endcase
  end

  // Root links, clear counter, configuration and result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      clr_cnt    <= '0;
      lru_enable <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (pw_en && (pw_addr == '0)) begin
        tail <= pw_data;
      end
      if (nw_en && (nw_addr == '0)) begin
        head <= nw_data;
      end
      if (cmd.op == lile_pkg::DP_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cfg_we) begin
        lru_enable <= cfg_data;
      end
      if (cmd.op == lile_pkg::DP_RESULT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign head_ext = 32'(head);
  assign tail_ext = 32'(tail);

  // Request capture, neighbor capture and result payload.
  always_ff @(posedge clk) begin
    if (cmd.op == lile_pkg::DP_LOAD) begin
      op_mode <= mode;
      node    <= idx_ext[AW-1:0];
      node_ok <= in_range;
    end
    if (cmd.op == lile_pkg::DP_EVAL) begin
      link_p <= prev_rd;
      link_q <= next_rd;
      ok     <= guard;
    end
    if (cmd.op == lile_pkg::DP_TAIL_A) begin
      tail_cap <= tail;
    end
    if (cmd.op == lile_pkg::DP_RESULT) begin
      applied    <= ok;
      list_empty <= head == '0;
      head_index <= head_ext[lile_pkg::IDX_W-1:0];
      tail_index <= tail_ext[lile_pkg::IDX_W-1:0];
    end
  end

endmodule

### rtl/core/lile_ctrl.sv
module lile_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lile_pkg::dp_status_t status,
  output lile_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_UNLINK_A,
    S_UNLINK_B,
    S_LINK_A,
    S_LINK_B,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // Command for the current step and the step that follows.
  always_comb begin
    cmd.op     = lile_pkg::DP_IDLE;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.op = lile_pkg::DP_CLEAR;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = lile_pkg::DP_LOAD;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.op = lile_pkg::DP_EVAL;
        if (!status.guard_ok) begin
          state_next = S_DONE;
        end else if (status.do_unlink) begin
          state_next = S_UNLINK_A;
        end else begin
          state_next = S_LINK_A;
        end
      end
      S_UNLINK_A: begin
        cmd.op     = lile_pkg::DP_UNLINK_A;
        state_next = S_UNLINK_B;
      end
      S_UNLINK_B: begin
        cmd.op = lile_pkg::DP_UNLINK_B;
        if (status.link_head || status.link_tail) begin
          state_next = S_LINK_A;
        end else begin
          state_next = S_DONE;
        end
      end
      S_LINK_A: begin
        cmd.op     = status.link_head ? lile_pkg::DP_HEAD_A : lile_pkg::DP_TAIL_A;
        state_next = S_LINK_B;
      end
      S_LINK_B: begin
        cmd.op     = status.link_head ? lile_pkg::DP_HEAD_B : lile_pkg::DP_TAIL_B;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.op     = lile_pkg::DP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // State register and registered ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= state_next == S_IDLE;
    end
  end

endmodule

### dv/lru_index_list_engine_core_tb.sv
`timescale 1ns / 100ps

module lru_index_list_engine_core_tb;

  localparam int IDX_W = lile_pkg::IDX_W;
  localparam int MODE_W = lile_pkg::MODE_W;
  localparam int NODES = lile_pkg::NODE_COUNT_DEF;
  localparam logic [IDX_W-1:0] ROOT = '0;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam int SMALL_SET = 12;

  typedef struct packed {
    logic             applied;
    logic             list_empty;
    logic [IDX_W-1:0] head_index;
    logic [IDX_W-1:0] tail_index;
  } list_status_t;

  // Tracks the link tables and predicts the status returned for each request.
  class lru_link_tracker;
    logic [IDX_W-1:0] prv[NODES];
    logic [IDX_W-1:0] nxt[NODES];
    bit               enable;
    list_status_t     expected_status[$];
    int               mismatches;

    function new();
      for (int i = 0; i < NODES; i++) begin
        prv[i] = IDX_W'(i);
        nxt[i] = IDX_W'(i);
      end
      enable = 1'b1;
      mismatches = 0;
    endfunction

    function void set_enable(bit v);
      enable = v;
    endfunction

    // Place n between p and q.
    function void splice(logic [IDX_W-1:0] n, logic [IDX_W-1:0] p, logic [IDX_W-1:0] q);
      prv[q] = n;
      nxt[n] = q;
      prv[n] = p;
      nxt[p] = n;
    endfunction

    // Join the neighbors of n and leave n pointing at itself.
    function void detach(logic [IDX_W-1:0] n);
      logic [IDX_W-1:0] p;
      logic [IDX_W-1:0] q;
      p = prv[n];
      q = nxt[n];
      prv[q] = p;
      nxt[p] = q;
      prv[n] = n;
      nxt[n] = n;
    endfunction

    function bit add_at_head(logic [IDX_W-1:0] n);
      if (n == ROOT || prv[n] == ROOT || nxt[n] != n || prv[n] != n) return 1'b0;
      splice(n, ROOT, nxt[ROOT]);
      return 1'b1;
    endfunction

    function bit add_at_tail(logic [IDX_W-1:0] n);
      if (!enable || n == ROOT || nxt[n] == ROOT || nxt[n] != n || prv[n] != n)
        return 1'b0;
      splice(n, prv[ROOT], ROOT);
      return 1'b1;
    endfunction

    // A move needs a linked node that is not already at the requested end.
    function bit move_ok(logic [IDX_W-1:0] n, logic [IDX_W-1:0] end_link);
      return enable && n != ROOT && end_link != ROOT && nxt[n] != n && prv[n] != n &&
             nxt[n] != prv[n];
    endfunction

    function void note_request(logic [MODE_W-1:0] op, logic [IDX_W-1:0] n);
      bit           ok;
      list_status_t s;
      ok = 1'b0;
      if (int'(n) < NODES) begin
        case (op)
          lile_pkg::MODE_ADD_HEAD: ok = add_at_head(n);
          lile_pkg::MODE_ADD_TAIL: ok = add_at_tail(n);
          lile_pkg::MODE_MOVE_HEAD: begin
            if (move_ok(n, prv[n])) begin
              detach(n);
              void'(add_at_head(n));
              ok = 1'b1;
            end
          end
          lile_pkg::MODE_MOVE_TAIL: begin
            if (move_ok(n, nxt[n])) begin
              detach(n);
              void'(add_at_tail(n));
              ok = 1'b1;
            end
          end
          lile_pkg::MODE_REMOVE: begin
            if (n != ROOT && nxt[n] != n && prv[n] != n) begin
              detach(n);
              ok = 1'b1;
            end
          end
          default: ok = 1'b0;
        endcase
      end
      s.applied = ok;
      s.list_empty = (nxt[ROOT] == ROOT);
      s.head_index = nxt[ROOT];
      s.tail_index = prv[ROOT];
      expected_status.push_back(s);
    endfunction

    function void check_status(list_status_t got);
      list_status_t want;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result applied=%0d empty=%0d head=%0d tail=%0d",
                   got.applied, got.list_empty, got.head_index, got.tail_index);
        return;
      end
      want = expected_status.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: exp a=%0d e=%0d h=%0d t=%0d, got a=%0d e=%0d h=%0d t=%0d",
                   want.applied, want.list_empty, want.head_index, want.tail_index,
                   got.applied, got.list_empty, got.head_index, got.tail_index);
      end
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function int error_count();
      return mismatches + expected_status.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic [MODE_W-1:0] mode;
  logic [IDX_W-1:0] node_index;
  logic             out_valid;
  logic             out_ready;
  logic             applied;
  logic             list_empty;
  logic [IDX_W-1:0] head_index;
  logic [IDX_W-1:0] tail_index;

  lru_link_tracker tracker;
  bit              no_gaps;
  int              stall_cycles;

  lru_index_list_engine_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .node_index (node_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .applied    (applied),
    .list_empty (list_empty),
    .head_index (head_index),
    .tail_index (tail_index)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Roughly one cycle in five is an idle cycle, except during quiet stretches.
  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(99) < 21);
  endfunction

  // Receiver side backpressure.
  always @(negedge clk) begin
    out_ready <= !take_gap();
  end

  // Requests and results are recorded at the edge where they are accepted.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) tracker.note_request(mode, node_index);
    if (!rst && out_valid && out_ready)
      tracker.check_status('{applied, list_empty, head_index, tail_index});
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Present one request and hold it until it is accepted.
  task automatic send_request(input logic [MODE_W-1:0] op, input logic [IDX_W-1:0] n);
    @(negedge clk);
    if (take_gap()) begin
      in_valid <= 1'b0;
      do @(negedge clk); while (take_gap());
    end
    in_valid <= 1'b1;
    mode <= op;
    node_index <= n;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every predicted result has been returned.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_enable(input bit v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_enable(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly list operations on a small set of nodes so that the list fills and
  // drains, with some root, unused mode and full range requests mixed in.
  task automatic random_requests(input int count, input int quiet_from, input int quiet_to);
    int               r;
    logic [MODE_W-1:0] op;
    logic [IDX_W-1:0] n;
    for (int i = 0; i < count; i++) begin
      no_gaps = (i >= quiet_from && i < quiet_to);
      r = $urandom_range(99);
      if (r < 24) op = lile_pkg::MODE_ADD_HEAD;
      else if (r < 42) op = lile_pkg::MODE_ADD_TAIL;
      else if (r < 58) op = lile_pkg::MODE_MOVE_HEAD;
      else if (r < 74) op = lile_pkg::MODE_MOVE_TAIL;
      else if (r < 93) op = lile_pkg::MODE_REMOVE;
      else op = MODE_W'(lile_pkg::MODE_REMOVE + $urandom_range(1, 3));
      r = $urandom_range(99);
      if (r < 88) n = IDX_W'($urandom_range(1, SMALL_SET));
      else if (r < 93) n = ROOT;
      else n = IDX_W'($urandom_range(NODES - 1));
      send_request(op, n);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    tracker = new();
    no_gaps = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    mode = lile_pkg::MODE_ADD_HEAD;
    node_index = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: guards on an empty list, ends of the index range, moves at the
    // ends, unused modes and the root node.
    write_enable(1'b1);
    send_request(lile_pkg::MODE_REMOVE, 10'd5);
    send_request(lile_pkg::MODE_MOVE_HEAD, 10'd5);
    send_request(lile_pkg::MODE_MOVE_TAIL, 10'd5);
    send_request(lile_pkg::MODE_ADD_TAIL, 10'd1023);
    send_request(lile_pkg::MODE_ADD_HEAD, 10'd1);
    send_request(lile_pkg::MODE_ADD_HEAD, 10'd1);
    send_request(lile_pkg::MODE_MOVE_HEAD, 10'd1023);
    send_request(lile_pkg::MODE_MOVE_TAIL, 10'd1023);
    send_request(lile_pkg::MODE_MOVE_TAIL, 10'd1023);
    send_request(lile_pkg::MODE_ADD_HEAD, 10'd512);
    send_request(lile_pkg::MODE_MOVE_HEAD, 10'd512);
    send_request(MODE_W'(lile_pkg::MODE_REMOVE + 1), 10'd1);
    send_request(MODE_W'(lile_pkg::MODE_REMOVE + 2), 10'd1);
    send_request(MODE_W'(lile_pkg::MODE_REMOVE + 3), 10'd1);
    send_request(lile_pkg::MODE_ADD_HEAD, ROOT);
    send_request(lile_pkg::MODE_ADD_TAIL, ROOT);
    send_request(lile_pkg::MODE_MOVE_HEAD, ROOT);
    send_request(lile_pkg::MODE_MOVE_TAIL, ROOT);
    send_request(lile_pkg::MODE_REMOVE, ROOT);
    send_request(lile_pkg::MODE_REMOVE, 10'd512);
    send_request(lile_pkg::MODE_REMOVE, 10'd1);
    send_request(lile_pkg::MODE_REMOVE, 10'd1023);

    // With the enable cleared only head insert and remove may act.
    write_enable(1'b0);
    send_request(lile_pkg::MODE_ADD_TAIL, 10'd2);
    send_request(lile_pkg::MODE_ADD_HEAD, 10'd2);
    send_request(lile_pkg::MODE_ADD_HEAD, 10'd3);
    send_request(lile_pkg::MODE_MOVE_TAIL, 10'd3);
    send_request(lile_pkg::MODE_MOVE_HEAD, 10'd2);
    send_request(lile_pkg::MODE_REMOVE, 10'd2);

    // Random phases across both register settings.
    write_enable(1'b1);
    random_requests(260, 80, 180);
    write_enable(1'b0);
    random_requests(140, 0, 0);
    write_enable(1'b1);
    random_requests(200, 0, 0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.error_count() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/lile_pkg.sv
rtl/core/lile_ram.sv
rtl/core/lile_datapath.sv
rtl/core/lile_ctrl.sv
rtl/core/lru_index_list_engine_core.sv
dv/lru_index_list_engine_core_tb.sv
